[rtl/hfc_pkg.sv]
// Shared types, codes and constants of the HTTP frame classifier.
package hfc_pkg;

	// Default offset of the IPv4 header inside the frame
	localparam int ETH_HEADER_BYTES_DEF = 14;

	// Result queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Frame byte position saturates here
	localparam logic [15:0] POS_MAX = 16'hffff;

	// Printable range of a request line
	localparam logic [7:0] PRINT_LO = 8'h20;
	localparam logic [7:0] PRINT_HI = 8'h7e;
	localparam logic [7:0] SPACE_CHAR = 8'h20;

	// Smallest legal IP / TCP header length in 32-bit words
	localparam logic [3:0] MIN_HDR_WORDS = 4'd5;

	// Result status codes
	localparam logic [2:0] ST_REQUEST   = 3'd0;
	localparam logic [2:0] ST_RESPONSE  = 3'd1;
	localparam logic [2:0] ST_NOT_HTTP  = 3'd2;
	localparam logic [2:0] ST_NO_PAYLD  = 3'd3;
	localparam logic [2:0] ST_BAD_IP    = 3'd4;
	localparam logic [2:0] ST_BAD_TCP   = 3'd5;
	localparam logic [2:0] ST_TRUNCATED = 3'd6;

	// Verdict codes of the payload scan
	localparam logic [1:0] V_UNDECIDED = 2'd0;
	localparam logic [1:0] V_REQUEST   = 2'd1;
	localparam logic [1:0] V_RESPONSE  = 2'd2;
	localparam logic [1:0] V_NOT_HTTP  = 2'd3;

	// Everything the back end needs of one finished frame
	typedef struct packed {
		logic [15:0] cnt;
		logic [3:0]  ipw;
		logic [3:0]  tcpw;
		logic [15:0] tlen;
		logic [1:0]  verdict;
		logic [31:0] src;
		logic [31:0] dst;
		logic [31:0] ports;
	} frame_sum_t;

	// Characters of "HTTP"
	function automatic logic [7:0] http_byte(input logic [1:0] i);
		logic [7:0] c;
		case (i)
			2'd0: c = 8'h48;
			2'd1: c = 8'h54;
			2'd2: c = 8'h54;
			default: c = 8'h50;
		endcase
		return c;
	endfunction

endpackage

[rtl/hfc_front.sv]
// Front end: parses frame bytes, scans the payload, emits a frame summary.
module hfc_front
	import hfc_pkg::*;
#(
	parameter int ETH_HEADER_BYTES = ETH_HEADER_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] data_byte,
	input  logic       frame_end,
	output logic       sum_valid,
	output frame_sum_t sum
);

	localparam logic [15:0] IPB = 16'(ETH_HEADER_BYTES);

	logic [15:0] pos_q, pos_d;
	logic [3:0]  ipw_q, ipw_d;
	logic [15:0] tlen_q, tlen_d;
	logic [3:0]  tcpw_q, tcpw_d;
	logic [31:0] src_q, src_d;
	logic [31:0] dst_q, dst_d;
	logic [31:0] ports_q, ports_d;
	logic [1:0]  sc_q, sc_d;
	logic [2:0]  mp_q, mp_d;
	logic [1:0]  verdict_q, verdict_d;
	logic        ro_q, ro_d;
	logic [15:0] pb_q, pb_d;
	logic [16:0] plen_q, plen_d;

	logic [15:0] tb;
	logic [15:0] k;
	logic        plen_pos;
	logic        cls_en;
	logic        done;
	logic [1:0]  sc_tmp;
	logic [6:0]  hdr_d;

	assign tb       = IPB + 16'({ipw_q, 2'b00});
	assign k        = pos_q - pb_q;
	assign plen_pos = !plen_q[16] && (plen_q != 17'd0);

	// Per-byte header capture and payload scan
	always_comb begin
		pos_d     = pos_q;
		ipw_d     = ipw_q;
		tlen_d    = tlen_q;
		tcpw_d    = tcpw_q;
		src_d     = src_q;
		dst_d     = dst_q;
		ports_d   = ports_q;
		sc_d      = sc_q;
		mp_d      = mp_q;
		verdict_d = verdict_q;
		ro_d      = ro_q;
		cls_en    = 1'b0;
		done      = 1'b0;
		sc_tmp    = sc_q;

		if (pos_q != POS_MAX) begin
			if (pos_q == IPB)
				ipw_d = data_byte[3:0];
			if (pos_q == IPB + 16'd2)
				tlen_d[15:8] = data_byte;
			if (pos_q == IPB + 16'd3)
				tlen_d[7:0] = data_byte;
			if (pos_q >= IPB + 16'd12 && pos_q <= IPB + 16'd15)
				src_d = {src_q[23:0], data_byte};
			if (pos_q >= IPB + 16'd16 && pos_q <= IPB + 16'd19)
				dst_d = {dst_q[23:0], data_byte};
			if (pos_q > IPB && ipw_q >= MIN_HDR_WORDS) begin
				if (pos_q >= tb && pos_q <= tb + 16'd3)
					ports_d = {ports_q[23:0], data_byte};
				if (pos_q == tb + 16'd12)
					tcpw_d = data_byte[7:4];
				if (tcpw_q >= MIN_HDR_WORDS && plen_pos && pos_q >= pb_q &&
				    k < plen_q[15:0] && verdict_q == V_UNDECIDED)
					cls_en = 1'b1;
			end
			pos_d = pos_q + 16'd1;
		end

		if (cls_en) begin
			// response: payload opens with HTTP
			if (k < 16'd4 && ro_q) begin
				if (data_byte == http_byte(k[1:0])) begin
					if (k[1:0] == 2'd3) begin
						verdict_d = V_RESPONSE;
						done      = 1'b1;
					end
				end else begin
					ro_d = 1'b0;
				end
			end
			// stop the first line at a non-printable byte
			if (!done && !(data_byte inside {[PRINT_LO:PRINT_HI]})) begin
				verdict_d = V_NOT_HTTP;
				done      = 1'b1;
			end
			// request: HTTP after the second space
			if (!done && mp_q != 3'd0) begin
				if (mp_q < 3'd5 && data_byte == http_byte(2'(mp_q - 3'd1))) begin
					mp_d = mp_q + 3'd1;
					if (mp_q == 3'd4) begin
						verdict_d = V_REQUEST;
						done      = 1'b1;
					end
				end else begin
					mp_d = 3'd0;
				end
			end
			if (!done && data_byte == SPACE_CHAR) begin
				if (sc_q != 2'd3)
					sc_tmp = sc_q + 2'd1;
				sc_d = sc_tmp;
				if (sc_tmp == 2'd2)
					mp_d = 3'd1;
			end
			// last payload byte without a decision
			if (!done && ({1'b0, k} + 17'd1) >= plen_q)
				verdict_d = V_NOT_HTTP;
		end
	end

	// Payload start and length from the updated header fields
	assign hdr_d  = {1'b0, ipw_d, 2'b00} + {1'b0, tcpw_d, 2'b00};
	assign pb_d   = IPB + 16'(hdr_d);
	assign plen_d = {1'b0, tlen_d} - 17'(hdr_d);

	// Advance the per-frame state; clear it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			ipw_q     <= '0;
			tlen_q    <= '0;
			tcpw_q    <= '0;
			src_q     <= '0;
			dst_q     <= '0;
			ports_q   <= '0;
			sc_q      <= '0;
			mp_q      <= '0;
			verdict_q <= V_UNDECIDED;
			ro_q      <= 1'b1;
			pb_q      <= IPB;
			plen_q    <= '0;
		end else if (take) begin
			if (frame_end) begin
				pos_q     <= '0;
				ipw_q     <= '0;
				tlen_q    <= '0;
				tcpw_q    <= '0;
				src_q     <= '0;
				dst_q     <= '0;
				ports_q   <= '0;
				sc_q      <= '0;
				mp_q      <= '0;
				verdict_q <= V_UNDECIDED;
				ro_q      <= 1'b1;
				pb_q      <= IPB;
				plen_q    <= '0;
			end else begin
				pos_q     <= pos_d;
				ipw_q     <= ipw_d;
				tlen_q    <= tlen_d;
				tcpw_q    <= tcpw_d;
				src_q     <= src_d;
				dst_q     <= dst_d;
				ports_q   <= ports_d;
				sc_q      <= sc_d;
				mp_q      <= mp_d;
				verdict_q <= verdict_d;
				ro_q      <= ro_d;
				pb_q      <= pb_d;
				plen_q    <= plen_d;
			end
		end
	end

	// Summary includes the last byte's update
	assign sum_valid    = take && frame_end;
	assign sum.cnt      = pos_d;
	assign sum.ipw      = ipw_d;
	assign sum.tcpw     = tcpw_d;
	assign sum.tlen     = tlen_d;
	assign sum.verdict  = verdict_d;
	assign sum.src      = src_d;
	assign sum.dst      = dst_d;
	assign sum.ports    = ports_d;

endmodule

[rtl/hfc_queue.sv]
// Short queue of frame summaries between front and back end.
module hfc_queue
	import hfc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  frame_sum_t wr_data,
	input  logic       rd_en,
	output frame_sum_t rd_data,
	output logic       full,
	output logic       empty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	frame_sum_t           entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [PTR_W:0]       cnt_q;

	assign full    = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = entry_q[rd_ptr_q];

	// Store a word
	always_ff @(posedge clk) begin
		if (wr_en && !full)
			entry_q[wr_ptr_q] <= wr_data;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en && !full)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (rd_en && !empty)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if ((wr_en && !full) && !(rd_en && !empty))
				cnt_q <= cnt_q + 1'b1;
			else if (!(wr_en && !full) && (rd_en && !empty))
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

[rtl/hfc_back.sv]
// Back end: turns a frame summary into the result word and holds it.
module hfc_back
	import hfc_pkg::*;
#(
	parameter int ETH_HEADER_BYTES = ETH_HEADER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  frame_sum_t  head,
	output logic        q_take,
	input  logic        pop,
	output logic        empty,
	output logic [2:0]  status,
	output logic [31:0] source_address,
	output logic [31:0] dest_address,
	output logic [15:0] source_port,
	output logic [15:0] dest_port,
	output logic [15:0] payload_bytes
);

	localparam logic [15:0] IPB = 16'(ETH_HEADER_BYTES);

	logic        out_valid_q;
	logic [2:0]  status_c;
	logic [31:0] ports_c;
	logic [15:0] pbytes_c;
	logic [15:0] tcp_lim;
	logic [6:0]  hdr;
	logic [16:0] plen;

	assign tcp_lim = IPB + 16'({head.ipw, 2'b00}) + 16'd12;
	assign hdr     = {1'b0, head.ipw, 2'b00} + {1'b0, head.tcpw, 2'b00};
	assign plen    = {1'b0, head.tlen} - 17'(hdr);

	// Decide the status in check order
	always_comb begin
		status_c = ST_TRUNCATED;
		ports_c  = head.ports;
		pbytes_c = '0;
		if (head.cnt <= IPB) begin
			status_c = ST_TRUNCATED;
		end else if (head.ipw < MIN_HDR_WORDS) begin
			status_c = ST_BAD_IP;
			ports_c  = '0;
		end else if (head.cnt <= tcp_lim) begin
			status_c = ST_TRUNCATED;
		end else if (head.tcpw < MIN_HDR_WORDS) begin
			status_c = ST_BAD_TCP;
		end else if (plen[16] || plen == 17'd0) begin
			status_c = ST_NO_PAYLD;
		end else begin
			pbytes_c = plen[15:0];
			case (head.verdict)
				V_REQUEST:  status_c = ST_REQUEST;
				V_RESPONSE: status_c = ST_RESPONSE;
				V_NOT_HTTP: status_c = ST_NOT_HTTP;
				default:    status_c = ST_TRUNCATED;
			endcase
		end
	end

	// Load the output register when it is free or being drained
	assign q_take = !q_empty && (!out_valid_q || pop);
	assign empty  = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (q_take)
			out_valid_q <= 1'b1;
		else if (pop)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (q_take) begin
			status         <= status_c;
			source_address <= head.src;
			dest_address   <= head.dst;
			source_port    <= ports_c[31:16];
			dest_port      <= ports_c[15:0];
			payload_bytes  <= pbytes_c;
		end
	end

endmodule

[rtl/http_frame_classifier.sv]
// Top level of the HTTP frame classifier.
//
// Input queue: one frame byte per word on data_byte, frame_end high on the
// last byte. A word is taken on a clock edge with push high and full low;
// one byte per cycle is sustained for as long as full stays low.
// Result queue: one word per frame, valid while empty is low, taken on an
// edge with pop high. status, addresses, ports and payload_bytes belong to
// the oldest result.
// The summary of a frame enters the queue at the edge that takes its last
// byte; the status decision then loads the output register from the queue
// head once that register is free or being popped.
// When the receiver stalls, results pile up in a four-entry summary queue
// plus the output register; full rises only when both are occupied, and
// bytes keep flowing until then.
// Reset (arst_n low) clears the parser state, empties the queue and drops
// any held result; the next byte is taken as the first of a frame.
module http_frame_classifier
	import hfc_pkg::*;
#(
	parameter int ETH_HEADER_BYTES = ETH_HEADER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        frame_end,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic [31:0] source_address,
	output logic [31:0] dest_address,
	output logic [15:0] source_port,
	output logic [15:0] dest_port,
	output logic [15:0] payload_bytes
);

	logic       take;
	logic       sum_valid;
	frame_sum_t sum;
	frame_sum_t head;
	logic       q_full;
	logic       q_empty;
	logic       q_take;

	assign full = q_full;
	assign take = push && !q_full;

	// Parse bytes
	hfc_front #(
		.ETH_HEADER_BYTES(ETH_HEADER_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (data_byte),
		.frame_end (frame_end),
		.sum_valid (sum_valid),
		.sum       (sum)
	);

	// Buffer frame summaries
	hfc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (sum_valid),
		.wr_data (sum),
		.rd_en   (q_take),
		.rd_data (head),
		.full    (q_full),
		.empty   (q_empty)
	);

	// Decide and present results
	hfc_back #(
		.ETH_HEADER_BYTES(ETH_HEADER_BYTES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.head           (head),
		.q_take         (q_take),
		.pop            (pop),
		.empty          (empty),
		.status         (status),
		.source_address (source_address),
		.dest_address   (dest_address),
		.source_port    (source_port),
		.dest_port      (dest_port),
		.payload_bytes  (payload_bytes)
	);

	// A taken last byte leaves a summary in the queue
	a_sum_queued: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid |=> !q_empty)
	else $error("frame summary lost on its way into the queue");

	// A summary moved to the back end shows up as a result
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |=> !empty)
	else $error("result register not loaded");

	// HTTP verdicts only come with a payload
	a_http_has_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (status == ST_REQUEST || status == ST_RESPONSE))
			|-> payload_bytes != 16'd0)
	else $error("HTTP status without payload length");

endmodule
